@@ hdl/bcvm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bcvm_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int CHAN_W    = 3;
    localparam int SUM_W     = 20;
    localparam int GAIN_W    = 16;
    localparam int CODE_W    = 16;
    localparam int TAP_W     = 31;
    localparam int DIVN_W    = 38;
    localparam int DIVD_W    = 24;
    localparam int DCNT_W    = 6;
    localparam int MV_W      = 16;
    localparam int BUCKET_W  = 4;
    localparam int CELLNUM_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_REGS = 6;
    localparam int THRESH_N  = 10;
    localparam int THRESH_W  = 9;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h2eaa;
    localparam logic [CODE_W-1:0] CODE_MAX   = 16'hffff;
    localparam logic [SUM_W-1:0]  SUM_MAX    = 20'hfffff;

    typedef logic [THRESH_W-1:0] thresh_t;
    localparam thresh_t THRESH_TABLE [THRESH_N] =
        '{9'd310, 9'd345, 9'd352, 9'd358, 9'd362, 9'd368, 9'd370, 9'd372, 9'd380, 9'd390};

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [DIVD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVN_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic signed [MV_W-1:0] mv;
        logic [BUCKET_W-1:0]    bucket;
    } eval_t;

endpackage
`default_nettype wire

@@ hdl/bcvm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface bcvm_sample_if;
    logic                           valid;
    logic                           ready;
    logic [bcvm_pkg::SAMPLE_W-1:0]  sample_value;
    logic [bcvm_pkg::CHAN_W-1:0]    channel_number;
    logic                           frame_end;
    modport source (output valid, sample_value, channel_number, frame_end, input ready);
    modport sink   (input valid, sample_value, channel_number, frame_end, output ready);
endinterface

interface bcvm_cell_if;
    logic                                valid;
    logic                                ready;
    logic [bcvm_pkg::CELLNUM_W-1:0]      cell_number;
    logic signed [bcvm_pkg::MV_W-1:0]    cell_millivolts;
    logic [bcvm_pkg::BUCKET_W-1:0]       charge_bucket;
    logic                                reference_fault;
    logic                                last_cell;
    modport source (output valid, cell_number, cell_millivolts, charge_bucket,
                    reference_fault, last_cell, input ready);
    modport sink   (input valid, cell_number, cell_millivolts, charge_bucket,
                    reference_fault, last_cell, output ready);
endinterface

interface bcvm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bcvm_pkg::CFG_IDX_W-1:0]     index;
    logic [bcvm_pkg::GAIN_W-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/bcvm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bcvm_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bcvm_pkg::div_req_t req,
    output bcvm_pkg::div_rsp_t      rsp
);
    import bcvm_pkg::*;

    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVN_W-1:0] quo_reg, quo_next;
    logic [DIVD_W-1:0] div_reg;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVD_W:0]   trial;

    // one restoring step per cycle, quotient bits shift in behind the dividend
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVN_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = DCNT_W'(DIVN_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = DIVD_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[DIVN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVD_W-1:0];
                quo_next = {quo_reg[DIVN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // hold operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
            div_reg <= req.divisor;
    end

    assign rsp = '{done: done_reg, quotient: quo_reg};
endmodule
`default_nettype wire

@@ hdl/bcvm_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bcvm_eval (
    input  wire logic [bcvm_pkg::TAP_W-1:0] tap,
    input  wire logic [bcvm_pkg::TAP_W-1:0] prev_tap,
    output bcvm_pkg::eval_t                 res
);
    import bcvm_pkg::*;

    logic signed [TAP_W:0]    cell_diff;
    logic signed [TAP_W+10:0] mv_prod;
    logic signed [TAP_W+7:0]  cv_prod;
    logic signed [TAP_W-2:0]  mv_full;
    logic signed [TAP_W-5:0]  cv;
    logic signed [MV_W-1:0]   mv_sat;
    logic [BUCKET_W-1:0]      bucket;

    // difference taps, scale to mV and cV with floor shifts
    always_comb
    begin
        cell_diff = $signed({1'b0, tap}) - $signed({1'b0, prev_tap});
        mv_prod   = (TAP_W+11)'(cell_diff) * $signed((TAP_W+11)'(1000));
        cv_prod   = (TAP_W+8)'(cell_diff) * $signed((TAP_W+8)'(100));
        mv_full   = mv_prod[TAP_W+10:12];
        cv        = cv_prod[TAP_W+7:12];
    end

    // saturate millivolts
    always_comb
    begin
        if (mv_full > $signed((TAP_W-1)'(32767)))
            mv_sat = 16'sd32767;
        else if (mv_full < $signed(-(TAP_W-1)'(32768)))
            mv_sat = -16'sd32768;
        else
            mv_sat = mv_full[MV_W-1:0];
    end

    // pick highest threshold met
    always_comb
    begin
        bucket = '0;
        if (!cv[TAP_W-5])
        begin
            for (int j = 0; j < THRESH_N; j++)
            begin
                if (cv >= $signed({(TAP_W-4-THRESH_W)'(0), THRESH_TABLE[j]}))
                    bucket = BUCKET_W'(j);
            end
        end
    end

    assign res = '{mv: mv_sat, bucket: bucket};
endmodule
`default_nettype wire

@@ hdl/battery_cell_voltage_monitor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Battery cell voltage monitor. Accepts a converter sample only once the
// previous one is done (read, add and write back of the channel sum in a
// registered-read memory); channel 0 is the reference, channels 1..CELLS are
// stack taps. Channel averages come from a reciprocal multiply by
// SAMPLES_PER_CHANNEL. On a frame-end sample the block stalls its input and
// reports CELLS result beats, one per cell, lowest tap first. Each cell runs
// two divisions on a shared one-bit-per-cycle divider; with a zero reference
// every cell skips the divisions and reports a reference fault. After each
// frame, and after reset, a clearing pass over all CHANNELS entries zeroes the
// sum memory before the next sample is taken. Gain registers 0..5 are written
// through the configuration channel; the user must write them only while the
// block is idle, which the block itself does not enforce. A gain of zero is
// treated as one.
module battery_cell_voltage_monitor #(
    parameter int CHANNELS            = 7,
    parameter int SAMPLES_PER_CHANNEL = 8,
    parameter int CELLS               = 6
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bcvm_sample_if.sink   samples,
    bcvm_cell_if.source   cells,
    bcvm_cfg_if.sink      cfg
);
    import bcvm_pkg::*;

    localparam int CH_W      = $clog2(CHANNELS);
    localparam int CELL_W    = 4;
    localparam int AVG_SH    = SUM_W + 8;
    localparam int AVG_PW    = SUM_W + AVG_SH;
    localparam int AVG_RECIP = ((1 << AVG_SH) + SAMPLES_PER_CHANNEL - 1)
                               / SAMPLES_PER_CHANNEL;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_RREF  = 4'd3;
    localparam logic [3:0] S_RAVG  = 4'd4;
    localparam logic [3:0] S_TRD   = 4'd5;
    localparam logic [3:0] S_TAVG  = 4'd6;
    localparam logic [3:0] S_CGO   = 4'd7;
    localparam logic [3:0] S_CWT   = 4'd8;
    localparam logic [3:0] S_VGO   = 4'd9;
    localparam logic [3:0] S_VWT   = 4'd10;
    localparam logic [3:0] S_EVAL  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]          state_reg, state_next;
    logic [CH_W-1:0]     clr_reg, clr_next;
    logic [CELL_W-1:0]   cell_reg, cell_next;
    logic [GAIN_W-1:0]   gains_reg [GAIN_REGS];

    logic [SAMPLE_W-1:0] smp_reg;
    logic [CH_W-1:0]     ch_reg;
    logic                ch_ok_reg;
    logic                fe_reg;
    logic                tap_ok_reg;
    logic [SUM_W-1:0]    ref_avg_reg;
    logic [SUM_W-1:0]    tap_avg_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [TAP_W-1:0]    tap_reg;
    logic [TAP_W-1:0]    prev_reg;

    logic                out_valid_reg;
    logic [CELLNUM_W-1:0] out_cell_reg;
    logic signed [MV_W-1:0] out_mv_reg;
    logic [BUCKET_W-1:0] out_bucket_reg;
    logic                out_fault_reg;
    logic                out_last_reg;

    logic [SUM_W-1:0]    sum_mem [CHANNELS];
    logic [SUM_W-1:0]    rd_q;
    logic                mem_we, mem_re;
    logic [CH_W-1:0]     mem_wa, mem_ra;
    logic [SUM_W-1:0]    mem_wd;

    logic                in_acc;
    logic                out_acc;
    logic [SUM_W:0]      sum_ext;
    logic [AVG_PW-1:0]   avg_prod;
    logic [SUM_W-1:0]    avg;
    logic [4:0]          tap_ch;
    logic                tap_ok;
    logic                is_last;
    logic [2:0]          gsel;
    logic [GAIN_W-1:0]   gain;
    logic [DIVD_W-1:0]   ref11;

    div_req_t            dreq;
    div_rsp_t            drsp;
    eval_t               ev;

    bcvm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    bcvm_eval u_eval (
        .tap      (tap_reg),
        .prev_tap (prev_reg),
        .res      (ev)
    );

    assign in_acc  = samples.valid && samples.ready;
    assign out_acc = cells.valid && cells.ready;
    assign samples.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;

    assign sum_ext  = {1'b0, rd_q} + (SUM_W+1)'(smp_reg);
    // average of the sum just read, exact for any sum below 2^SUM_W
    assign avg_prod = AVG_PW'(rd_q) * AVG_PW'(AVG_RECIP);
    assign avg      = avg_prod[AVG_PW-1:AVG_SH];
    assign tap_ch  = 5'(cell_reg) + 5'd1;
    assign tap_ok  = (tap_ch < 5'(CHANNELS));
    assign is_last = (cell_reg == CELL_W'(CELLS - 1));
    assign gsel    = (cell_reg < CELL_W'(GAIN_REGS)) ? cell_reg[2:0] : 3'(GAIN_REGS - 1);
    assign gain    = (gains_reg[gsel] == '0) ? GAIN_W'(1) : gains_reg[gsel];
    assign ref11   = (DIVD_W'(ref_avg_reg) << 3) + (DIVD_W'(ref_avg_reg) << 1)
                   + DIVD_W'(ref_avg_reg);

    // sum memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            sum_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_q <= sum_mem[mem_ra];
    end

    // sequence memory accesses, divider requests and state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cell_next  = cell_reg;
        mem_we     = 1'b0;
        mem_wa     = ch_reg;
        mem_wd     = '0;
        mem_re     = 1'b0;
        mem_ra     = '0;
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = '0;
        unique case (state_reg)
            S_CLR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CH_W'(CHANNELS - 1))
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    mem_re     = 1'b1;
                    mem_ra     = CH_W'(samples.channel_number);
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                mem_we = ch_ok_reg;
                mem_wd = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                state_next = fe_reg ? S_RREF : S_IDLE;
            end
            S_RREF:
            begin
                mem_re     = 1'b1;
                state_next = S_RAVG;
            end
            S_RAVG:
            begin
                cell_next  = '0;
                state_next = S_TRD;
            end
            S_TRD:
            begin
                mem_re     = tap_ok;
                mem_ra     = CH_W'(tap_ch);
                state_next = (ref_avg_reg == '0) ? S_OUT : S_TAVG;
            end
            S_TAVG:
            begin
                state_next = S_CGO;
            end
            S_CGO:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = {tap_avg_reg, 18'd0};
                dreq.divisor  = ref11;
                state_next    = S_CWT;
            end
            S_CWT:
            begin
                if (drsp.done)
                    state_next = S_VGO;
            end
            S_VGO:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = DIVN_W'({1'b0, code_reg, 14'd0} + {3'd0, code_reg, 12'd0});
                dreq.divisor  = DIVD_W'(gain);
                state_next    = S_VWT;
            end
            S_VWT:
            begin
                if (drsp.done)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    if (is_last)
                        state_next = S_CLR;
                    else
                    begin
                        cell_next  = cell_reg + 1'b1;
                        state_next = S_TRD;
                    end
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            cell_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < GAIN_REGS; i++)
                gains_reg[i] <= GAIN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cell_reg  <= cell_next;
            // raise result beat, drop it once taken
            if (out_acc)
                out_valid_reg <= 1'b0;
            else if (state_reg == S_EVAL
                     || (state_reg == S_TRD && ref_avg_reg == '0))
                out_valid_reg <= 1'b1;
            if (cfg.valid && cfg.ready && cfg.index < CFG_IDX_W'(GAIN_REGS))
                gains_reg[cfg.index] <= cfg.data;
        end
    end

    // capture datapath values
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            smp_reg   <= samples.sample_value;
            ch_reg    <= CH_W'(samples.channel_number);
            ch_ok_reg <= (5'(samples.channel_number) < 5'(CHANNELS));
            fe_reg    <= samples.frame_end;
        end
        if (state_reg == S_RAVG)
        begin
            ref_avg_reg <= avg;
            prev_reg    <= '0;
        end
        if (state_reg == S_TRD)
            tap_ok_reg <= tap_ok;
        if (state_reg == S_TAVG)
            tap_avg_reg <= tap_ok_reg ? avg : '0;
        if (state_reg == S_CWT && drsp.done)
            code_reg <= (drsp.quotient > DIVN_W'(CODE_MAX)) ? CODE_MAX
                                                            : drsp.quotient[CODE_W-1:0];
        if (state_reg == S_VWT && drsp.done)
            tap_reg <= drsp.quotient[TAP_W-1:0];
        if (state_reg == S_EVAL)
        begin
            prev_reg       <= tap_reg;
            out_mv_reg     <= ev.mv;
            out_bucket_reg <= ev.bucket;
            out_fault_reg  <= 1'b0;
        end
        else if (state_reg == S_TRD && ref_avg_reg == '0)
        begin
            out_mv_reg     <= '0;
            out_bucket_reg <= '0;
            out_fault_reg  <= 1'b1;
        end
        if (state_reg == S_TRD)
        begin
            out_cell_reg <= cell_reg[CELLNUM_W-1:0];
            out_last_reg <= is_last;
        end
    end

    assign cells.valid           = out_valid_reg;
    assign cells.cell_number     = out_cell_reg;
    assign cells.cell_millivolts = out_mv_reg;
    assign cells.charge_bucket   = out_bucket_reg;
    assign cells.reference_fault = out_fault_reg;
    assign cells.last_cell       = out_last_reg;
endmodule
`default_nettype wire
